[rtl/core/rtsph_pkg.sv]
package rtsph_pkg;

  // texture geometry
  localparam int TEX_BITS = 7;
  localparam int TEX_SIZE = 1 << TEX_BITS;
  localparam int ADDR_W   = 2 * TEX_BITS;
  localparam int TEXELS   = 1 << ADDR_W;

  // field widths
  localparam int IN_ADDR_W = 14;
  localparam int TEXEL_W   = 32;
  localparam int STEP_W    = 26;
  localparam int ZOOM_W    = 25;
  localparam int RADIUS_W  = 8;
  localparam int CNT_W     = 9;

  // 16.16 accumulators
  localparam int ACC_W     = 32;
  localparam int FRAC_BITS = 16;
  localparam logic [ACC_W-1:0] TEX_MID = ACC_W'(TEX_SIZE) << (FRAC_BITS - 1);

  // cycles the start-value pipeline needs after a register write or reset
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  // config reset values
  localparam logic [STEP_W-1:0]   COS_RESET    = STEP_W'(65536);
  localparam logic [STEP_W-1:0]   SIN_RESET    = '0;
  localparam logic [ZOOM_W-1:0]   ZOOM_RESET   = ZOOM_W'(65536);
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);

  typedef enum logic [1:0] {
    KIND_ALBEDO = 2'd0,
    KIND_SHADE  = 2'd1,
    KIND_PIXEL  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_COS    = 2'd0,
    CFG_SIN    = 2'd1,
    CFG_ZOOM   = 2'd2,
    CFG_RADIUS = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [STEP_W-1:0]   cos_step;
    logic [STEP_W-1:0]   sin_step;
    logic [ZOOM_W-1:0]   zoom_step;
    logic [RADIUS_W-1:0] sprite_radius;
  } cfg_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } pix_tag_t;

endpackage

[rtl/core/rtsph_ram.sv]
module rtsph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read that holds when not enabled
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

[rtl/core/rtsph_coord.sv]
module rtsph_coord import rtsph_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              step,
  output logic [ADDR_W-1:0] alb_addr,
  output logic [ADDR_W-1:0] sh_addr,
  output pix_tag_t          tag_r
);

  logic [CNT_W-1:0] w;
  logic [ACC_W-1:0] w_ext, cos_ext, sin_ext, zoom_ext;
  logic [ACC_W-1:0] cos_half, sin_half, zoom_half;

  logic [ACC_W-1:0] p_wc_r, p_ws_r, p_wz_r;
  logic [ACC_W-1:0] st_u_r, st_v_r, st_s_r;

  logic [ACC_W-1:0] run_u_r, run_v_r, run_s_r, row_u_r, row_v_r, row_t_r, start_s_r;
  logic [ACC_W-1:0] run_u_nxt, run_v_nxt, run_s_nxt, row_u_nxt, row_v_nxt, row_t_nxt;
  logic [ACC_W-1:0] start_s_nxt;
  logic [CNT_W-1:0] col_r, row_r, col_nxt, row_nxt;
  pix_tag_t         tag_nxt;

  logic             first;
  logic [ACC_W-1:0] eu, ev, es, erow_u, erow_v, erow_t, estart_s;

  // step values, sign or zero extended, and their halves
  assign w         = {cfg.sprite_radius, 1'b0};
  assign w_ext     = ACC_W'(w);
  assign cos_ext   = {{(ACC_W-STEP_W){cfg.cos_step[STEP_W-1]}}, cfg.cos_step};
  assign sin_ext   = {{(ACC_W-STEP_W){cfg.sin_step[STEP_W-1]}}, cfg.sin_step};
  assign zoom_ext  = ACC_W'(cfg.zoom_step);
  assign cos_half  = {cos_ext[ACC_W-1], cos_ext[ACC_W-1:1]};
  assign sin_half  = {sin_ext[ACC_W-1], sin_ext[ACC_W-1:1]};
  assign zoom_half = {1'b0, zoom_ext[ACC_W-1:1]};

  // frame start values: products, then sums, tracking config continuously
  always_ff @(posedge clk) begin
    p_wc_r <= w_ext * cos_half;
    p_ws_r <= w_ext * sin_half;
    p_wz_r <= w_ext * zoom_half;
    st_u_r <= TEX_MID - p_wc_r + p_ws_r;
    st_v_r <= TEX_MID - p_ws_r - p_wc_r;
    st_s_r <= TEX_MID - p_wz_r;
  end

  // accumulator values seen by this pixel
  always_comb begin
    first    = (col_r == '0) && (row_r == '0);
    eu       = first ? st_u_r : run_u_r;
    ev       = first ? st_v_r : run_v_r;
    es       = first ? st_s_r : run_s_r;
    erow_u   = first ? st_u_r : row_u_r;
    erow_v   = first ? st_v_r : row_v_r;
    erow_t   = first ? st_s_r : row_t_r;
    estart_s = first ? st_s_r : start_s_r;
  end

  // texel addresses from the integer parts
  assign alb_addr = {ev[FRAC_BITS +: TEX_BITS], eu[FRAC_BITS +: TEX_BITS]};
  assign sh_addr  = {erow_t[FRAC_BITS +: TEX_BITS], es[FRAC_BITS +: TEX_BITS]};

  // accumulator and counter advance
  always_comb begin
    run_u_nxt   = run_u_r;
    run_v_nxt   = run_v_r;
    run_s_nxt   = run_s_r;
    row_u_nxt   = row_u_r;
    row_v_nxt   = row_v_r;
    row_t_nxt   = row_t_r;
    start_s_nxt = start_s_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    tag_nxt     = tag_r;
    if (step) begin
      start_s_nxt       = estart_s;
      tag_nxt.row_end   = 1'b0;
      tag_nxt.frame_end = 1'b0;
      if (col_r >= w) begin
        row_u_nxt       = erow_u - sin_ext;
        row_v_nxt       = erow_v + cos_ext;
        row_t_nxt       = erow_t + zoom_ext;
        run_u_nxt       = row_u_nxt;
        run_v_nxt       = row_v_nxt;
        run_s_nxt       = estart_s;
        col_nxt         = '0;
        tag_nxt.row_end = 1'b1;
        if (row_r >= w) begin
          row_nxt           = '0;
          tag_nxt.frame_end = 1'b1;
        end else begin
          row_nxt = row_r + CNT_W'(1);
        end
      end else begin
        row_u_nxt = erow_u;
        row_v_nxt = erow_v;
        row_t_nxt = erow_t;
        run_u_nxt = eu + cos_ext;
        run_v_nxt = ev + sin_ext;
        run_s_nxt = es + zoom_ext;
        col_nxt   = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_u_r   <= '0;
      run_v_r   <= '0;
      run_s_r   <= '0;
      row_u_r   <= '0;
      row_v_r   <= '0;
      row_t_r   <= '0;
      start_s_r <= '0;
      col_r     <= '0;
      row_r     <= '0;
      tag_r     <= '0;
    end else begin
      run_u_r   <= run_u_nxt;
      run_v_r   <= run_v_nxt;
      run_s_r   <= run_s_nxt;
      row_u_r   <= row_u_nxt;
      row_v_r   <= row_v_nxt;
      row_t_r   <= row_t_nxt;
      start_s_r <= start_s_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      tag_r     <= tag_nxt;
    end
  end

endmodule

[rtl/core/rtsph_shade.sv]
module rtsph_shade import rtsph_pkg::*; (
  input  logic               clk,
  input  logic               load,
  input  logic [TEXEL_W-1:0] alb_texel,
  input  logic [TEXEL_W-1:0] sh_texel,
  input  pix_tag_t           tag,
  output logic [TEXEL_W-1:0] pixel_r,
  output pix_tag_t           tag_out_r
);

  logic [15:0]        prod [4];
  logic [TEXEL_W-1:0] scaled;
  logic [TEXEL_W-1:0] pixel_nxt;

  // each albedo channel times the shading byte, keep the high byte
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i]          = 16'(alb_texel[8*i +: 8]) * 16'(sh_texel[7:0]);
      scaled[8*i +: 8] = prod[i][15:8];
    end
    pixel_nxt = scaled | {sh_texel[31:24], 24'h000000};
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      pixel_r   <= pixel_nxt;
      tag_out_r <= tag;
    end
  end

endmodule

[rtl/core/rotated_texture_sphere_shader.sv]
// Rotozoom sphere sprite shader.
// Input channel (in_valid/in_ready): each request is a texel write to the
// albedo store, a texel write to the shading store, or a pixel request.
// Output channel (out_valid/out_ready): one shaded pixel per pixel request,
// in row-major order, with row_end and frame_end marks on the last pixel of
// a row and of the sprite. Writes give no output.
// Config channel (cfg_valid/cfg_ready): register index and data; always
// ready. Write config only while no pixel is in flight.
// Throughput: one request per clock while in_ready is high; a pixel request
// passes the store read, then the shading multiply into the output register.
// The two single-port texture memories set the pace: one access per cycle.
// After reset and after every config write, in_ready stays low while the
// frame start values are recomputed from the registers.
// Reset clears accumulators and counters and loads the config defaults;
// the texture stores are not cleared and must be written before use.
// When the receiver stalls, the output register holds, one pixel waits in
// the read stage, and in_ready drops once both are full.
module rotated_texture_sphere_shader import rtsph_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_kind,
  input  logic [IN_ADDR_W-1:0] in_texel_address,
  input  logic [TEXEL_W-1:0]   in_texel_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TEXEL_W-1:0]   out_pixel,
  output logic                 out_row_end,
  output logic                 out_frame_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t cfg_r;
  logic [1:0] settle_r, settle_nxt;
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;

  logic in_acc, cfg_acc, pix_acc, alb_we, sh_we;
  logic out_free, s1_go;
  logic [ADDR_W-1:0] wr_addr, alb_addr, sh_addr, alb_ram_addr, sh_ram_addr;
  logic [TEXEL_W-1:0] alb_texel, sh_texel;
  pix_tag_t s1_tag, out_tag;

  // handshake and request decode
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign s1_go     = s1_valid_r && out_free;
  assign in_ready  = (settle_r == '0) && (!s1_valid_r || out_free);
  assign in_acc    = in_valid && in_ready;
  assign pix_acc   = in_acc && (in_kind == KIND_PIXEL);
  assign alb_we    = in_acc && (in_kind == KIND_ALBEDO);
  assign sh_we     = in_acc && (in_kind == KIND_SHADE);
  assign wr_addr   = ADDR_W'(in_texel_address);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_step      <= COS_RESET;
      cfg_r.sin_step      <= SIN_RESET;
      cfg_r.zoom_step     <= ZOOM_RESET;
      cfg_r.sprite_radius <= RADIUS_RESET;
    end else if (cfg_acc) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COS:    cfg_r.cos_step      <= cfg_data[STEP_W-1:0];
        CFG_SIN:    cfg_r.sin_step      <= cfg_data[STEP_W-1:0];
        CFG_ZOOM:   cfg_r.zoom_step     <= cfg_data[ZOOM_W-1:0];
        CFG_RADIUS: cfg_r.sprite_radius <= cfg_data[RADIUS_W-1:0];
      endcase
    end
  end

  // settle counter, pipeline valids
  always_comb begin
    if (cfg_acc) begin
      settle_nxt = SETTLE_CYCLES;
    end else if (settle_r != '0) begin
      settle_nxt = settle_r - 2'd1;
    end else begin
      settle_nxt = settle_r;
    end
    if (pix_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r    <= SETTLE_CYCLES;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      settle_r    <= settle_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // coordinate generator
  rtsph_coord u_coord (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .step     (pix_acc),
    .alb_addr (alb_addr),
    .sh_addr  (sh_addr),
    .tag_r    (s1_tag)
  );

  // texture stores
  assign alb_ram_addr = alb_we ? wr_addr : alb_addr;
  assign sh_ram_addr  = sh_we ? wr_addr : sh_addr;

  rtsph_ram #(.WIDTH(TEXEL_W), .DEPTH(TEXELS)) u_albedo_ram (
    .clk     (clk),
    .we      (alb_we),
    .re      (pix_acc),
    .addr    (alb_ram_addr),
    .wdata   (in_texel_data),
    .rdata_r (alb_texel)
  );

  rtsph_ram #(.WIDTH(TEXEL_W), .DEPTH(TEXELS)) u_shade_ram (
    .clk     (clk),
    .we      (sh_we),
    .re      (pix_acc),
    .addr    (sh_ram_addr),
    .wdata   (in_texel_data),
    .rdata_r (sh_texel)
  );

  // shading and output register
  rtsph_shade u_shade (
    .clk       (clk),
    .load      (s1_go),
    .alb_texel (alb_texel),
    .sh_texel  (sh_texel),
    .tag       (s1_tag),
    .pixel_r   (out_pixel),
    .tag_out_r (out_tag)
  );

  assign out_valid     = out_valid_r;
  assign out_row_end   = out_tag.row_end;
  assign out_frame_end = out_tag.frame_end;

`ifndef SYNTH
  a_no_s1_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |-> !pix_acc)
    else $error("read stage overwritten while stalled");

  a_settle_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (settle_r != '0) |-> !in_ready)
    else $error("request taken while start values settle");

  a_pix_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    pix_acc |=> s1_valid_r)
    else $error("pixel request lost before read stage");

  a_frame_has_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_end) |-> out_row_end)
    else $error("frame end without row end");
`endif

endmodule

[dv/rotated_texture_sphere_shader_test.sv]
module rotated_texture_sphere_shader_test;
  import rtsph_pkg::*;

  // the one input kind the block has no use for
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // texel at the middle of the texture, where a zero-radius frame starts
  localparam logic [ADDR_W-1:0] MID_TEXEL = ADDR_W'((TEX_SIZE / 2) * TEX_SIZE + TEX_SIZE / 2);

  localparam int ITEM_TARGET     = 1000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 4 * SETTLE_CYCLES;

  typedef struct packed {
    logic [TEXEL_W-1:0] pixel;
    pix_tag_t           tag;
  } shaded_pixel_t;

  // shader state mirror and queue of pixels still owed by the block
  class pixel_scoreboard;
    logic [TEXEL_W-1:0]  albedo_mem [TEXELS];
    logic [TEXEL_W-1:0]  shade_mem [TEXELS];
    bit                  albedo_set [TEXELS];
    bit                  shade_set [TEXELS];
    logic [STEP_W-1:0]   cos_step;
    logic [STEP_W-1:0]   sin_step;
    logic [ZOOM_W-1:0]   zoom_step;
    logic [RADIUS_W-1:0] radius;
    logic [ACC_W-1:0]    run_u, run_v, run_s, row_u, row_v, row_t, start_s;
    logic [CNT_W-1:0]    col_cnt, row_cnt;
    shaded_pixel_t       owed_q [$];
    int                  errors;

    function new();
      cos_step  = COS_RESET;
      sin_step  = SIN_RESET;
      zoom_step = ZOOM_RESET;
      radius    = RADIUS_RESET;
      run_u = '0; run_v = '0; run_s = '0;
      row_u = '0; row_v = '0; row_t = '0; start_s = '0;
      col_cnt = '0; row_cnt = '0;
      errors = 0;
    endfunction

    function void load_register(cfg_idx_t idx, logic [31:0] data);
      case (idx)
        CFG_COS:    cos_step  = data[STEP_W-1:0];
        CFG_SIN:    sin_step  = data[STEP_W-1:0];
        CFG_ZOOM:   zoom_step = data[ZOOM_W-1:0];
        CFG_RADIUS: radius    = data[RADIUS_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [ACC_W-1:0] step_value(logic [STEP_W-1:0] raw);
      return {{(ACC_W - STEP_W){raw[STEP_W-1]}}, raw};
    endfunction

    // frame start values: centered, backed off by half a sprite of steps
    function void frame_start(output logic [ACC_W-1:0] u, v, s, t);
      logic [ACC_W-1:0] w, ch, sh, zh;
      w  = ACC_W'(radius) << 1;
      ch = $signed(step_value(cos_step)) >>> 1;
      sh = $signed(step_value(sin_step)) >>> 1;
      zh = ACC_W'(zoom_step) >> 1;
      u = TEX_MID - w * ch + w * sh;
      v = TEX_MID - w * sh - w * ch;
      s = TEX_MID - w * zh;
      t = TEX_MID - w * zh;
    endfunction

    // texels the next pixel request will read
    function void peek_fetch(output logic [ADDR_W-1:0] albedo_at, shade_at);
      logic [ACC_W-1:0] u, v, s, t;
      u = run_u;
      v = run_v;
      s = run_s;
      t = row_t;
      if (col_cnt == 0 && row_cnt == 0) frame_start(u, v, s, t);
      albedo_at = {v[FRAC_BITS +: TEX_BITS], u[FRAC_BITS +: TEX_BITS]};
      shade_at  = {t[FRAC_BITS +: TEX_BITS], s[FRAC_BITS +: TEX_BITS]};
    endfunction

    function void note_request(logic [1:0] kind, logic [IN_ADDR_W-1:0] addr,
                               logic [TEXEL_W-1:0] data);
      logic [ADDR_W-1:0]  ai, si;
      logic [ACC_W-1:0]   cv, sv, zv;
      logic [TEXEL_W-1:0] albedo, shade;
      logic [CNT_W-1:0]   w;
      logic [15:0]        prod;
      shaded_pixel_t      want;
      if (kind == KIND_ALBEDO) begin
        albedo_mem[addr[ADDR_W-1:0]] = data;
        albedo_set[addr[ADDR_W-1:0]] = 1'b1;
        return;
      end
      if (kind == KIND_SHADE) begin
        shade_mem[addr[ADDR_W-1:0]] = data;
        shade_set[addr[ADDR_W-1:0]] = 1'b1;
        return;
      end
      if (kind != KIND_PIXEL) return;

      // fetch, then load the start values on the first pixel of a frame
      peek_fetch(ai, si);
      if (col_cnt == 0 && row_cnt == 0) begin
        frame_start(row_u, row_v, start_s, row_t);
        run_u = row_u;
        run_v = row_v;
        run_s = start_s;
      end
      albedo = albedo_mem[ai];
      shade  = shade_mem[si];

      // scale every albedo channel by the shading byte, or in shading alpha
      for (int i = 0; i < 4; i++) begin
        prod = albedo[8*i +: 8] * shade[7:0];
        want.pixel[8*i +: 8] = prod[15:8];
      end
      want.pixel[31:24] = want.pixel[31:24] | shade[31:24];

      // advance along the row, and to the next row at its end
      cv = step_value(cos_step);
      sv = step_value(sin_step);
      zv = ACC_W'(zoom_step);
      w  = CNT_W'(radius) << 1;
      run_u += cv;
      run_v += sv;
      run_s += zv;
      want.tag = '0;
      if (col_cnt >= w) begin
        want.tag.row_end = 1'b1;
        row_u -= sv;
        row_v += cv;
        row_t += zv;
        run_u = row_u;
        run_v = row_v;
        run_s = start_s;
        col_cnt = '0;
        if (row_cnt >= w) begin
          want.tag.frame_end = 1'b1;
          row_cnt = '0;
        end else begin
          row_cnt = row_cnt + 1'b1;
        end
      end else begin
        col_cnt = col_cnt + 1'b1;
      end
      owed_q.push_back(want);
    endfunction

    function void check_pixel(logic [TEXEL_W-1:0] pixel, logic row_end, logic frame_end);
      shaded_pixel_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: pixel %h with none expected", $time, pixel);
        return;
      end
      want = owed_q.pop_front();
      if (pixel !== want.pixel) begin
        errors++;
        $display("%0t: pixel expected %h actual %h", $time, want.pixel, pixel);
      end
      if (row_end !== want.tag.row_end) begin
        errors++;
        $display("%0t: row_end expected %b actual %b", $time, want.tag.row_end, row_end);
      end
      if (frame_end !== want.tag.frame_end) begin
        errors++;
        $display("%0t: frame_end expected %b actual %b", $time, want.tag.frame_end,
                 frame_end);
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_kind = KIND_UNUSED;
  logic [IN_ADDR_W-1:0] in_texel_address = '0;
  logic [TEXEL_W-1:0]   in_texel_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [TEXEL_W-1:0]   out_pixel;
  logic                 out_row_end;
  logic                 out_frame_end;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = CFG_COS;
  logic [31:0]          cfg_data = '0;

  pixel_scoreboard sb;
  int              idle_odds = 0;
  bit              hold_off_req = 1'b0;
  int              sent_count = 0;

  rotated_texture_sphere_shader dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_texel_address (in_texel_address),
    .in_texel_data    (in_texel_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel        (out_pixel),
    .out_row_end      (out_row_end),
    .out_frame_end    (out_frame_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5000000;
    $display("rotated_texture_sphere_shader_test: errors");
    $finish;
  end

  // texel data, with the all-zero and all-one patterns now and then
  function automatic logic [TEXEL_W-1:0] pick_texel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 7))
      0:       return 32'hff00_0000;
      1:       return 32'h0100_0000;
      2:       return 32'h0200_0000;
      3:       return 32'h01ff_ffff;
      4:       return $urandom;
      5:       return '0;
      default: return $urandom_range(0, 32'h60000) - 32'h30000;
    endcase
  endfunction

  function automatic logic [31:0] pick_zoom();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'h0100_0000;
      2:       return 32'h01ff_ffff;
      3:       return $urandom;
      default: return $urandom_range(0, 32'h30000);
    endcase
  endfunction

  function automatic logic [31:0] pick_radius();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return $urandom;
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  // one request on the input channel; valid stays up for a following request
  task automatic send_request(logic [1:0] kind, logic [IN_ADDR_W-1:0] addr,
                              logic [TEXEL_W-1:0] data);
    if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_texel_address <= addr;
    in_texel_data    <= data;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(kind, addr, data);
    if (kind != KIND_UNUSED) sent_count++;
  endtask

  // one register write request; valid is lowered by the caller
  task automatic write_register(cfg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.load_register(idx, data);
  endtask

  task automatic program_registers(logic [31:0] cos_v, logic [31:0] sin_v,
                                   logic [31:0] zoom_v, logic [31:0] radius_v);
    write_register(CFG_COS, cos_v);
    write_register(CFG_SIN, sin_v);
    write_register(CFG_ZOOM, zoom_v);
    write_register(CFG_RADIUS, radius_v);
    cfg_valid <= 1'b0;
  endtask

  // stop sending and wait until every owed pixel is out and the block settles
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // pixel requests, each preceded by writes of any texel it would read unwritten
  task automatic run_pixels(int count, int noise_odds, int rewrite_odds);
    logic [ADDR_W-1:0] ai, si;
    for (int p = 0; p < count; p++) begin
      if (noise_odds != 0 && $urandom_range(0, noise_odds - 1) == 0) begin
        case ($urandom_range(0, 2))
          0:       send_request(KIND_ALBEDO, IN_ADDR_W'($urandom), pick_texel());
          1:       send_request(KIND_SHADE, IN_ADDR_W'($urandom), pick_texel());
          default: send_request(KIND_UNUSED, IN_ADDR_W'($urandom), $urandom);
        endcase
      end
      sb.peek_fetch(ai, si);
      if (!sb.albedo_set[ai] || $urandom_range(0, rewrite_odds - 1) == 0)
        send_request(KIND_ALBEDO, ai, pick_texel());
      if (!sb.shade_set[si] || $urandom_range(0, rewrite_odds - 1) == 0)
        send_request(KIND_SHADE, si, pick_texel());
      send_request(KIND_PIXEL, IN_ADDR_W'($urandom), $urandom);
    end
  endtask

  // result side: check accepted pixels, stall in bursts or for a long hold-off
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready)
        sb.check_pixel(out_pixel, out_row_end, out_frame_end);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int phase;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // ignored kind, and writes at the address and data extremes
    send_request(KIND_UNUSED, '1, '1);
    send_request(KIND_ALBEDO, '0, '1);
    send_request(KIND_SHADE, '1, '0);

    // zero steps: a 3x3 frame reading the middle texel, full then zero shading
    drain();
    program_registers('0, '0, '0, 32'd1);
    send_request(KIND_ALBEDO, MID_TEXEL, '1);
    send_request(KIND_SHADE, MID_TEXEL, '1);
    run_pixels(4, 0, 1000);
    send_request(KIND_SHADE, MID_TEXEL, '0);
    run_pixels(5, 0, 1000);

    // radius zero: one-pixel frames, with the step registers at their extremes
    drain();
    program_registers(32'h0200_0000, 32'h01ff_ffff, 32'h01ff_ffff, 32'd0);
    send_request(KIND_SHADE, MID_TEXEL, 32'h7f00_0080);
    run_pixels(2, 0, 1000);

    // random phases; each new setting lands mid-frame more often than not
    phase = 0;
    while (sent_count < ITEM_TARGET) begin
      drain();
      if (sent_count > ITEM_TARGET * 4 / 5) begin
        idle_odds = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       idle_odds = 0;
          1:       idle_odds = 3;
          default: idle_odds = 6;
        endcase
      end
      if (phase == 2) begin
        // largest sprite, fine steps, with the receiver holding off at the start
        program_registers(32'h1000, 32'h0800, 32'h0c00, 32'd255);
        hold_off_req = 1'b1;
        run_pixels(515, 0, 16);
      end else begin
        program_registers(pick_step(), pick_step(), pick_zoom(), pick_radius());
        run_pixels($urandom_range(10, 80), 8, 6);
      end
      phase++;
    end

    drain();
    if (sb.errors == 0) begin
      $display("rotated_texture_sphere_shader_test: clean");
    end else begin
      $display("rotated_texture_sphere_shader_test: errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/rtsph_pkg.sv
rtl/core/rtsph_ram.sv
rtl/core/rtsph_coord.sv
rtl/core/rtsph_shade.sv
rtl/core/rotated_texture_sphere_shader.sv
dv/rotated_texture_sphere_shader_test.sv
